// File: rtl/fsp_pkg.sv
// Types, character codes and helper functions for the format specifier parser.
`default_nettype none
package fsp_pkg;

    typedef struct packed {
        logic [7:0]         ch;
        logic signed [31:0] star_arg;
    } fsp_in_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [4:0]         flag_mask;
        logic [30:0]        field_width;
        logic signed [31:0] precision;
        logic [1:0]         h_count;
        logic [1:0]         l_count;
        logic               j_seen;
        logic               z_seen;
        logic [7:0]         type_char;
    } fsp_out_t;

    typedef enum logic [3:0] {
        MODE_IDLE  = 4'b0001,
        MODE_WIDTH = 4'b0010,
        MODE_DOT   = 4'b0100,
        MODE_PREC  = 4'b1000
    } mode_t;

    typedef struct packed {
        mode_t              mode;
        logic [4:0]         flags;
        logic [30:0]        width;
        logic signed [31:0] precision;
        logic [1:0]         h_cnt;
        logic [1:0]         l_cnt;
        logic               j_mod;
        logic               z_mod;
    } fsp_state_t;

    localparam logic [1:0] STATUS_MORE  = 2'd0;
    localparam logic [1:0] STATUS_DONE  = 2'd1;
    localparam logic [1:0] STATUS_ERROR = 2'd2;

    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_H     = 8'h68;
    localparam logic [7:0] CH_L     = 8'h6C;
    localparam logic [7:0] CH_J     = 8'h6A;
    localparam logic [7:0] CH_Z     = 8'h7A;
    localparam logic [7:0] CH_NUL   = 8'h00;

    localparam int FLAG_HASH  = 0;
    localparam int FLAG_ZERO  = 1;
    localparam int FLAG_MINUS = 2;
    localparam int FLAG_PLUS  = 3;
    localparam int FLAG_SPACE = 4;

    localparam logic [30:0]        VAL_MAX   = 31'h7FFF_FFFF;
    localparam logic signed [31:0] PREC_NONE = 32'hFFFF_FFFF;

    localparam fsp_state_t RESET_STATE = '{
        mode:      MODE_IDLE,
        flags:     5'd0,
        width:     31'd0,
        precision: PREC_NONE,
        h_cnt:     2'd0,
        l_cnt:     2'd0,
        j_mod:     1'b0,
        z_mod:     1'b0
    };

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    // v * 10 + d, saturating at VAL_MAX
    function automatic logic [30:0] accumulate(input logic [30:0] v, input logic [3:0] d);
        logic [34:0] r;
        r = {1'b0, v, 3'b000} + {3'b000, v, 1'b0} + {31'd0, d};
        if (r > {4'd0, VAL_MAX})
            return VAL_MAX;
        return r[30:0];
    endfunction

    function automatic fsp_out_t make_result(input fsp_state_t s, input logic [1:0] status,
                                             input logic [7:0] type_char);
        fsp_out_t r;
        r.status      = status;
        r.flag_mask   = s.flags;
        r.field_width = s.width;
        r.precision   = s.precision;
        r.h_count     = s.h_cnt;
        r.l_count     = s.l_cnt;
        r.j_seen      = s.j_mod;
        r.z_seen      = s.z_mod;
        r.type_char   = type_char;
        return r;
    endfunction

endpackage
`default_nettype wire

// File: rtl/fsp_step.sv
// Next-state and result logic for one character of a conversion specification.
`default_nettype none
module fsp_step (
    input  fsp_pkg::fsp_state_t cur,
    input  fsp_pkg::fsp_in_t    item,
    output fsp_pkg::fsp_state_t nxt,
    output fsp_pkg::fsp_out_t   res
);
    import fsp_pkg::*;

    fsp_state_t  st;
    logic        handled;
    logic        fail;
    logic        done;
    logic        digit;
    logic [3:0]  dval;
    logic        mods;
    logic [31:0] mag;
    logic [7:0]  c;

    always_comb
    begin
        c       = item.ch;
        st      = cur;
        handled = 1'b0;
        fail    = 1'b0;
        done    = 1'b0;
        digit   = is_digit(c);
        dval    = c[3:0];
        mods    = (|cur.h_cnt) | (|cur.l_cnt) | cur.j_mod | cur.z_mod;
        mag     = item.star_arg[31] ? (32'd0 - item.star_arg) : item.star_arg;

        case (cur.mode)
            MODE_WIDTH:
            begin
                if (digit)
                begin
                    st.width = accumulate(cur.width, dval);
                    handled  = 1'b1;
                end
                else
                begin
                    st.mode = MODE_IDLE;
                end
            end
            MODE_DOT:
            begin
                st.mode = MODE_IDLE;
                if (c == CH_STAR)
                begin
                    st.precision = item.star_arg[31] ? PREC_NONE : item.star_arg;
                    handled      = 1'b1;
                end
                else if (digit)
                begin
                    st.precision = {28'd0, dval};
                    st.mode      = MODE_PREC;
                    handled      = 1'b1;
                end
            end
            MODE_PREC:
            begin
                if (digit)
                begin
                    st.precision = {1'b0, accumulate(cur.precision[30:0], dval)};
                    handled      = 1'b1;
                end
                else
                begin
                    st.mode = MODE_IDLE;
                end
            end
            default:
            begin
                st.mode = MODE_IDLE;
            end
        endcase

        if (!handled)
        begin
            case (c)
                CH_HASH:  st.flags[FLAG_HASH]  = 1'b1;
                CH_ZERO:  st.flags[FLAG_ZERO]  = 1'b1;
                CH_MINUS: st.flags[FLAG_MINUS] = 1'b1;
                CH_PLUS:  st.flags[FLAG_PLUS]  = 1'b1;
                CH_SPACE: st.flags[FLAG_SPACE] = 1'b1;
                CH_H:     if (st.h_cnt != 2'd3) st.h_cnt = st.h_cnt + 2'd1;
                CH_L:     if (st.l_cnt != 2'd3) st.l_cnt = st.l_cnt + 2'd1;
                CH_J:     st.j_mod = 1'b1;
                CH_Z:     st.z_mod = 1'b1;
                CH_DOT:
                begin
                    if (mods)
                    begin
                        fail = 1'b1;
                    end
                    else
                    begin
                        st.precision = 32'sd0;
                        st.mode      = MODE_DOT;
                    end
                end
                CH_STAR:
                begin
                    if (mods || (st.precision != PREC_NONE))
                    begin
                        fail = 1'b1;
                    end
                    else
                    begin
                        if (item.star_arg[31])
                            st.flags[FLAG_MINUS] = 1'b1;
                        // magnitude of the most negative argument saturates
                        st.width = mag[31] ? VAL_MAX : mag[30:0];
                    end
                end
                default:
                begin
                    if ((c >= CH_ONE) && (c <= CH_NINE))
                    begin
                        if (mods || (st.precision != PREC_NONE))
                        begin
                            fail = 1'b1;
                        end
                        else
                        begin
                            st.width = {27'd0, dval};
                            st.mode  = MODE_WIDTH;
                        end
                    end
                    else
                    begin
                        done = 1'b1;
                    end
                end
            endcase
        end

        if (fail)
        begin
            nxt = RESET_STATE;
            res = make_result(RESET_STATE, STATUS_ERROR, CH_NUL);
        end
        else if (done)
        begin
            nxt = RESET_STATE;
            res = make_result(st, STATUS_DONE, c);
        end
        else
        begin
            nxt = st;
            res = make_result(st, STATUS_MORE, CH_NUL);
        end
    end

endmodule
`default_nettype wire

// File: rtl/format_spec_parser.sv
// Each character is held in the input register, and its result in the result register.
// Throughput: one character per cycle while the consumer takes results; fsp_step is combinational.
// A stalled result holds in the result register while the next character waits in the input
// register, so both sides keep moving whenever the consumer takes results.
// Reset (rst_n low, asynchronous) empties both registers and returns the parser to its idle
// state with no flags, zero width, no precision and no length modifiers.
`default_nettype none
module format_spec_parser (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               in_valid,
    output logic              in_ready,
    input  fsp_pkg::fsp_in_t  in_data,
    output logic              out_valid,
    input  wire               out_ready,
    output fsp_pkg::fsp_out_t out_data
);
    import fsp_pkg::*;

    logic       in_valid_reg;
    fsp_in_t    in_data_reg;
    logic       out_valid_reg;
    fsp_out_t   out_data_reg;
    fsp_state_t state_reg;
    fsp_state_t state_next;
    fsp_out_t   step_res;
    logic       advance;

    fsp_step u_step (
        .cur  (state_reg),
        .item (in_data_reg),
        .nxt  (state_next),
        .res  (step_res)
    );

    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= RESET_STATE;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            in_data_reg <= in_data;
        if (advance)
            out_data_reg <= step_res;
    end

    // an empty result register never blocks the input side
    a_no_block: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> in_ready)
        else $error("input stalled with empty result register");

    a_err_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (step_res.status == STATUS_ERROR)) |=>
            (state_reg == RESET_STATE))
        else $error("state not cleared after error");

    a_done_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (step_res.status == STATUS_DONE)) |=>
            (state_reg == RESET_STATE))
        else $error("state not cleared after complete specification");

    a_more_no_type: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_data_reg.status == STATUS_MORE)) |->
            (out_data_reg.type_char == CH_NUL))
        else $error("type reported before specification complete");

    a_prec_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.mode == MODE_PREC) |-> !state_reg.precision[31])
        else $error("negative precision inside digit run");

endmodule
`default_nettype wire

// File: verif/tb_top.sv
// Testbench for format_spec_parser: directed and random text checked against a predictor.
`timescale 1ns / 100ps

import fsp_pkg::*;

class spec_scoreboard;
    localparam longint SAT_LIMIT = 64'd2147483647;

    fsp_out_t pending_results[$];
    int       fail_count;
    int       results_seen;

    // predictor copy of the parser state
    mode_t      parse_state;
    logic [4:0] flags;
    longint     width_acc;
    longint     prec_acc;
    logic [1:0] h_cnt;
    logic [1:0] l_cnt;
    logic       j_mod;
    logic       z_mod;

    function new();
        fail_count   = 0;
        results_seen = 0;
        clear_spec();
    endfunction

    function void clear_spec();
        parse_state = MODE_IDLE;
        flags       = '0;
        width_acc   = 0;
        prec_acc    = -1;
        h_cnt       = '0;
        l_cnt       = '0;
        j_mod       = 1'b0;
        z_mod       = 1'b0;
    endfunction

    function fsp_out_t snapshot(logic [1:0] status, logic [7:0] type_char);
        fsp_out_t r;
        r.status      = status;
        r.flag_mask   = flags;
        r.field_width = width_acc[30:0];
        r.precision   = prec_acc[31:0];
        r.h_count     = h_cnt;
        r.l_count     = l_cnt;
        r.j_seen      = j_mod;
        r.z_seen      = z_mod;
        r.type_char   = type_char;
        return r;
    endfunction

    function fsp_out_t fail_spec();
        clear_spec();
        return snapshot(STATUS_ERROR, CH_NUL);
    endfunction

    function bit is_dec(logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function longint times_ten_plus(longint v, longint d);
        longint r;
        r = v * 10 + d;
        return (r > SAT_LIMIT) ? SAT_LIMIT : r;
    endfunction

    function fsp_out_t parse_char(fsp_in_t item);
        logic [7:0] c;
        longint     arg;
        longint     digit;
        bit         has_mods;
        fsp_out_t   done;
        c     = item.ch;
        arg   = longint'(item.star_arg);
        digit = longint'(c) - longint'(CH_ZERO);

        case (parse_state)
            MODE_WIDTH:
            begin
                if (is_dec(c))
                begin
                    width_acc = times_ten_plus(width_acc, digit);
                    return snapshot(STATUS_MORE, CH_NUL);
                end
                parse_state = MODE_IDLE;
            end
            MODE_DOT:
            begin
                parse_state = MODE_IDLE;
                if (c == CH_STAR)
                begin
                    prec_acc = (arg < 0) ? -1 : arg;
                    return snapshot(STATUS_MORE, CH_NUL);
                end
                if (is_dec(c))
                begin
                    prec_acc    = digit;
                    parse_state = MODE_PREC;
                    return snapshot(STATUS_MORE, CH_NUL);
                end
            end
            MODE_PREC:
            begin
                if (is_dec(c))
                begin
                    prec_acc = times_ten_plus(prec_acc, digit);
                    return snapshot(STATUS_MORE, CH_NUL);
                end
                parse_state = MODE_IDLE;
            end
            default: ;
        endcase

        has_mods = (h_cnt != 2'd0) || (l_cnt != 2'd0) || j_mod || z_mod;

        case (c)
            CH_HASH:  flags[FLAG_HASH]  = 1'b1;
            CH_ZERO:  flags[FLAG_ZERO]  = 1'b1;
            CH_MINUS: flags[FLAG_MINUS] = 1'b1;
            CH_PLUS:  flags[FLAG_PLUS]  = 1'b1;
            CH_SPACE: flags[FLAG_SPACE] = 1'b1;
            CH_H: if (h_cnt != 2'd3) h_cnt = h_cnt + 2'd1;
            CH_L: if (l_cnt != 2'd3) l_cnt = l_cnt + 2'd1;
            CH_J: j_mod = 1'b1;
            CH_Z: z_mod = 1'b1;
            CH_DOT:
            begin
                if (has_mods)
                    return fail_spec();
                prec_acc    = 0;
                parse_state = MODE_DOT;
            end
            CH_STAR:
            begin
                if (has_mods || prec_acc != -1)
                    return fail_spec();
                if (arg < 0)
                begin
                    flags[FLAG_MINUS] = 1'b1;
                    arg = -arg;
                end
                width_acc = (arg > SAT_LIMIT) ? SAT_LIMIT : arg;
            end
            default:
            begin
                if (c >= CH_ONE && c <= CH_NINE)
                begin
                    if (has_mods || prec_acc != -1)
                        return fail_spec();
                    width_acc   = digit;
                    parse_state = MODE_WIDTH;
                end
                else
                begin
                    // anything outside the spec alphabet closes the spec as its type
                    done = snapshot(STATUS_DONE, c);
                    clear_spec();
                    return done;
                end
            end
        endcase
        return snapshot(STATUS_MORE, CH_NUL);
    endfunction

    function void note_char(fsp_in_t item);
        pending_results.push_back(parse_char(item));
    endfunction

    task report_mismatch(string what);
        fail_count++;
        if (fail_count <= 50)
            $display("MISMATCH @%0t: %s", $time, what);
    endtask

    task check_result(fsp_out_t got);
        fsp_out_t want;
        results_seen++;
        if (pending_results.size() == 0)
        begin
            report_mismatch($sformatf("result %0d arrived with nothing pending", results_seen));
            return;
        end
        want = pending_results.pop_front();
        if (got.status !== want.status)
            report_mismatch($sformatf("result %0d status %0d, want %0d",
                                      results_seen, got.status, want.status));
        if (got.flag_mask !== want.flag_mask)
            report_mismatch($sformatf("result %0d flag_mask %b, want %b",
                                      results_seen, got.flag_mask, want.flag_mask));
        if (got.field_width !== want.field_width)
            report_mismatch($sformatf("result %0d field_width %0d, want %0d",
                                      results_seen, got.field_width, want.field_width));
        if (got.precision !== want.precision)
            report_mismatch($sformatf("result %0d precision %0d, want %0d",
                                      results_seen, got.precision, want.precision));
        if (got.h_count !== want.h_count)
            report_mismatch($sformatf("result %0d h_count %0d, want %0d",
                                      results_seen, got.h_count, want.h_count));
        if (got.l_count !== want.l_count)
            report_mismatch($sformatf("result %0d l_count %0d, want %0d",
                                      results_seen, got.l_count, want.l_count));
        if (got.j_seen !== want.j_seen)
            report_mismatch($sformatf("result %0d j_seen %b, want %b",
                                      results_seen, got.j_seen, want.j_seen));
        if (got.z_seen !== want.z_seen)
            report_mismatch($sformatf("result %0d z_seen %b, want %b",
                                      results_seen, got.z_seen, want.z_seen));
        if (got.type_char !== want.type_char)
            report_mismatch($sformatf("result %0d type_char %h, want %h",
                                      results_seen, got.type_char, want.type_char));
    endtask
endclass

module tb_top;
    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_ready;
    fsp_in_t  in_data;
    logic     out_valid;
    logic     out_ready;
    fsp_out_t out_data;

    spec_scoreboard spec_sb;
    fsp_in_t        spec_chars[$];
    int             chars_sent;
    bit             idle_on;
    bit             hold_request;
    int             hold_left;
    int             drain_cycles;
    string          conv_chars;

    format_spec_parser DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("*** FAILED ***");
        $finish;
    end

    task automatic queue_char(input logic [7:0] c, input logic signed [31:0] arg);
        fsp_in_t item;
        item.ch       = c;
        item.star_arg = arg;
        spec_chars.push_back(item);
    endtask

    task automatic queue_text(input string s);
        for (int i = 0; i < s.len(); i++)
            queue_char(s[i], $urandom);
    endtask

    function automatic logic signed [31:0] pick_star_arg();
        case ($urandom_range(0, 5))
            0: return 32'sh8000_0000;
            1: return 32'sh7FFF_FFFF;
            2: return -1;
            3: return 0;
            4: return $signed($urandom_range(0, 199)) - 100;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [7:0] pick_flag_char();
        case ($urandom_range(0, 4))
            0: return CH_HASH;
            1: return CH_ZERO;
            2: return CH_MINUS;
            3: return CH_PLUS;
            default: return CH_SPACE;
        endcase
    endfunction

    function automatic logic [7:0] pick_mod_char();
        case ($urandom_range(0, 3))
            0: return CH_H;
            1: return CH_L;
            2: return CH_J;
            default: return CH_Z;
        endcase
    endfunction

    // digit run, mostly short; now and then long enough to saturate
    task automatic queue_digits(input bit nonzero_lead);
        int run_len;
        run_len = ($urandom_range(0, 11) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 3);
        if (nonzero_lead)
            queue_char(CH_ONE + 8'($urandom_range(0, 8)), $urandom);
        else
            queue_char(CH_ZERO + 8'($urandom_range(0, 9)), $urandom);
        repeat (run_len - 1)
            queue_char(CH_ZERO + 8'($urandom_range(0, 9)), $urandom);
    endtask

    task automatic build_random_spec();
        int         n;
        logic [7:0] conv;
        if ($urandom_range(0, 7) == 0)
        begin
            // noise: raw bytes mixed with spec characters
            n = $urandom_range(1, 6);
            repeat (n)
            begin
                case ($urandom_range(0, 5))
                    0: queue_char(pick_flag_char(), $urandom);
                    1: queue_char(pick_mod_char(), $urandom);
                    2: queue_char(CH_ONE + 8'($urandom_range(0, 8)), $urandom);
                    3: queue_char(CH_DOT, $urandom);
                    4: queue_char(CH_STAR, pick_star_arg());
                    default: queue_char(8'($urandom_range(0, 255)), $urandom);
                endcase
            end
            return;
        end

        n = $urandom_range(0, 3);
        repeat (n) queue_char(pick_flag_char(), $urandom);

        case ($urandom_range(0, 3))
            1: queue_digits(1'b1);
            2: queue_char(CH_STAR, pick_star_arg());
            3:
            begin
                // width given twice, later one wins
                queue_digits(1'b1);
                queue_char(CH_STAR, pick_star_arg());
            end
            default: ;
        endcase

        case ($urandom_range(0, 3))
            1: queue_char(CH_DOT, $urandom);
            2:
            begin
                queue_char(CH_DOT, $urandom);
                queue_digits(1'b0);
            end
            3:
            begin
                queue_char(CH_DOT, $urandom);
                queue_char(CH_STAR, pick_star_arg());
            end
            default: ;
        endcase

        n = ($urandom_range(0, 9) == 0) ? $urandom_range(3, 5) : $urandom_range(0, 2);
        repeat (n) queue_char(pick_mod_char(), $urandom);

        // misplaced width or precision
        if ($urandom_range(0, 9) == 0)
        begin
            case ($urandom_range(0, 2))
                0: queue_digits(1'b1);
                1: queue_char(CH_DOT, $urandom);
                default: queue_char(CH_STAR, pick_star_arg());
            endcase
        end

        case ($urandom_range(0, 9))
            0: conv = CH_NUL;
            1: conv = 8'($urandom_range(0, 255));
            default: conv = conv_chars[$urandom_range(0, conv_chars.len() - 1)];
        endcase
        queue_char(conv, $urandom);
    endtask

    task automatic send_char(input fsp_in_t item);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge clk); while (!in_ready);
        spec_sb.note_char(item);
        chars_sent++;
    endtask

    task automatic send_queued();
        while (spec_chars.size() != 0)
            send_char(spec_chars.pop_front());
    endtask

    // result side: check each transfer, then pick next ready
    initial
    begin
        out_ready <= 1'b0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid === 1'b1 && out_ready === 1'b1)
                spec_sb.check_result(out_data);
            if (!rst_n)
                out_ready <= 1'b0;
            else if (hold_request)
            begin
                // long hold so the parser backs up into its input
                hold_request = 1'b0;
                hold_left    = 39;
                out_ready   <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 4) == 0)
            begin
                hold_left  = $urandom_range(0, 2);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    initial
    begin
        spec_sb      = new();
        chars_sent   = 0;
        idle_on      = 1'b1;
        hold_request = 1'b0;
        conv_chars   = "diouxXcspfeEgGaAn%";
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        in_data  <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // all flags, most negative star width, negative star precision, width after it,
        // h count saturation
        queue_text("#0-+ ");
        queue_char(CH_STAR, 32'sh8000_0000);
        queue_char(CH_DOT, $urandom);
        queue_char(CH_STAR, -5);
        queue_text("7hhhhd");
        // precision after modifiers
        queue_text("ljz.");
        // width after precision (the star width that follows .5)
        queue_text(".5");
        // largest star width and precision, then end of string
        queue_char(CH_STAR, 32'sh7FFF_FFFF);
        queue_char(CH_DOT, $urandom);
        queue_char(CH_STAR, 32'sh7FFF_FFFF);
        queue_char(CH_NUL, $urandom);
        // width after modifier
        queue_text("h5");
        // zero flag, zero inside width, dot with no digits, top byte as type
        queue_text("010.");
        queue_char(8'hFF, $urandom);
        send_queued();

        while (chars_sent < 800)
        begin
            if (chars_sent >= 700)
                idle_on = 1'b0;
            if (chars_sent >= 300 && chars_sent < 320)
                hold_request = 1'b1;
            build_random_spec();
            send_queued();
        end
        in_valid <= 1'b0;

        drain_cycles = 0;
        while (spec_sb.pending_results.size() != 0 && drain_cycles < 1000)
        begin
            @(posedge clk);
            drain_cycles++;
        end
        repeat (10) @(posedge clk);
        if (spec_sb.pending_results.size() != 0)
            spec_sb.report_mismatch($sformatf("%0d results never arrived",
                                              spec_sb.pending_results.size()));

        if (spec_sb.fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
